@@ rtl/ppc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pursuit controller package
// Shared widths, register indexes, the vectoring arctangent table and the
// record that travels down the row of vectoring cells.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int VECTORING_STEPS = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int CELLS = (VECTORING_STEPS < ATAN_ENTRIES) ? VECTORING_STEPS : ATAN_ENTRIES;
  localparam int STEP_W = $clog2(ATAN_ENTRIES);

  // Vector components carry signed Q16.8 offsets plus growth headroom.
  localparam int CW = 28;

  localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;
  localparam logic [16:0] DIST_MAX     = 17'd92681;

  localparam logic [15:0] LINEAR_GAIN_RST   = 16'd6554;
  localparam logic [15:0] ANGULAR_GAIN_RST  = 16'd32768;
  localparam logic [15:0] STOP_DISTANCE_RST = 16'd3277;

  typedef enum logic [1:0] {
    CFG_LINEAR_GAIN   = 2'd0,
    CFG_ANGULAR_GAIN  = 2'd1,
    CFG_STOP_DISTANCE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic                 zero;
    logic [15:0]          heading;
  } cord_t;

  function automatic logic [31:0] atan_angle(input logic [STEP_W-1:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ppc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pursuit controller input stage
// Registers a request, forms the position offset in signed Q16.8 and folds the
// left half plane onto the right one before vectoring starts.
// ----------------------------------------------------------------------------
module ppc_front
  import ppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] leader_x,
  input  logic [15:0] leader_y,
  input  logic [15:0] follower_x,
  input  logic [15:0] follower_y,
  input  logic [15:0] follower_heading,
  input  logic        dn_advance,
  output logic        out_valid,
  output cord_t       out_data
);

  logic                 take;
  logic signed [16:0]   dx;
  logic signed [16:0]   dy;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  cord_t                data_next;

  assign take     = !out_valid || dn_advance;
  assign in_stall = !take;

  always_comb begin
    dx = $signed({1'b0, leader_x}) - $signed({1'b0, follower_x});
    dy = $signed({1'b0, leader_y}) - $signed({1'b0, follower_y});
    xs = CW'(dx) <<< 8;
    ys = CW'(dy) <<< 8;
    data_next.heading = follower_heading;
    data_next.zero    = (dx == 17'sd0) && (dy == 17'sd0);
    if (dx < 17'sd0) begin
      data_next.x = -xs;
      data_next.y = -ys;
      data_next.z = 32'h80000000;
    end else begin
      data_next.x = xs;
      data_next.y = ys;
      data_next.z = 32'h00000000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_valid;
    end
    if (take && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ppc_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pursuit controller vectoring cell
// One rotation step: drives y toward zero and accumulates the rotated angle.
// ----------------------------------------------------------------------------
module ppc_cell
  import ppc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [STEP_W-1:0] step,
  input  logic              in_valid,
  input  cord_t             in_data,
  output logic              up_advance,
  input  logic              dn_advance,
  output logic              out_valid,
  output cord_t             out_data
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [31:0]          ang;
  cord_t                data_next;

  assign up_advance = !out_valid || dn_advance;

  always_comb begin
    xs  = in_data.x >>> step;
    ys  = in_data.y >>> step;
    ang = atan_angle(step);
    data_next = in_data;
    if (!in_data.y[CW-1]) begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ang;
    end else begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_advance) begin
      out_valid <= in_valid;
    end
    if (up_advance && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ppc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pursuit controller output stages
// Removes the vectoring gain, applies the stop test and both gains, and
// holds the result register toward the consumer.
// ----------------------------------------------------------------------------
module ppc_back
  import ppc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  cord_t              in_data,
  output logic               up_advance,
  input  logic [15:0]        linear_gain,
  input  logic [15:0]        angular_gain,
  input  logic [15:0]        stop_distance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        forward_speed,
  output logic signed [15:0] turn_rate,
  output logic               stopped
);

  // Distance product stage.
  logic                    valid_d;
  logic signed [CW+16:0]   dist_prod;
  logic                    zero_d;
  logic [15:0]             err_d;
  // Gain product stage.
  logic                    valid_e;
  logic [32:0]             fwd_prod;
  logic signed [32:0]      tr_prod;
  logic                    stop_e;

  logic                    adv_d;
  logic                    adv_e;
  logic                    adv_o;
  logic [15:0]             bearing;
  logic signed [CW+16:0]   dist_round;
  logic signed [20:0]      dist_s;
  logic [16:0]             distance;
  logic [33:0]             fwd_round;
  logic signed [32:0]      tr_round;

  assign adv_o      = !out_valid || !out_stall;
  assign adv_e      = !valid_e || adv_o;
  assign adv_d      = !valid_d || adv_e;
  assign up_advance = adv_d;

  always_comb begin
    bearing    = in_data.zero ? 16'd0 : 16'((in_data.z + 32'h00008000) >> 16);
    dist_round = dist_prod + (CW+17)'(1 << 23);
    dist_s     = dist_round[CW+16:24];
    if (zero_d || dist_s < 21'sd0) begin
      distance = 17'd0;
    end else if (dist_s > $signed({4'd0, DIST_MAX})) begin
      distance = DIST_MAX;
    end else begin
      distance = dist_s[16:0];
    end
    fwd_round = {1'b0, fwd_prod} + 34'd32768;
    tr_round  = tr_prod + 33'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d   <= 1'b0;
      valid_e   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_d) begin
        valid_d <= in_valid;
      end
      if (adv_e) begin
        valid_e <= valid_d;
      end
      if (adv_o) begin
        out_valid <= valid_e;
      end
    end
    if (adv_d && in_valid) begin
      dist_prod <= in_data.x * $signed(INV_GAIN_Q16);
      zero_d    <= in_data.zero;
      err_d     <= bearing - in_data.heading;
    end
    if (adv_e && valid_d) begin
      fwd_prod <= distance * linear_gain;
      tr_prod  <= $signed(err_d) * $signed({1'b0, angular_gain});
      stop_e   <= ({1'b0, stop_distance} > distance);
    end
    if (adv_o && valid_e) begin
      forward_speed <= stop_e ? 17'd0 : fwd_round[32:16];
      turn_rate     <= tr_round[31:16];
      stopped       <= stop_e;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pursuit_proportional_controller_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pursuit proportional controller
// Steers a follower toward a leader: forward speed from the distance, turn
// rate from the heading error, through a row of vectoring cells.
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid / in_stall     leader/follower pose
//   output    out        out_valid / out_stall   forward_speed, turn_rate,
//                                                stopped
//   config    in         cfg_write               cfg_index, cfg_data
//
// One request is taken every cycle while in_stall is low. The stages are
// input register, 16 vectoring cells, distance product, gain products and
// result register; the cell row sets the latency. Every stage is one step.
// A stalled result holds only the stages behind it that are full, so empty
// slots keep closing up and requests keep entering.
// Reset clears all valid bits and loads the default gains and stop distance.
// ----------------------------------------------------------------------------
module pursuit_proportional_controller_core
  import ppc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        leader_x,
  input  logic [15:0]        leader_y,
  input  logic [15:0]        follower_x,
  input  logic [15:0]        follower_y,
  input  logic signed [15:0] follower_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        forward_speed,
  output logic signed [15:0] turn_rate,
  output logic               stopped
);

  logic [15:0] linear_gain;
  logic [15:0] angular_gain;
  logic [15:0] stop_distance;

  logic  cell_valid [CELLS+1];
  cord_t cell_data  [CELLS+1];
  logic  cell_adv   [CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain   <= LINEAR_GAIN_RST;
      angular_gain  <= ANGULAR_GAIN_RST;
      stop_distance <= STOP_DISTANCE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LINEAR_GAIN:   linear_gain   <= cfg_data;
        CFG_ANGULAR_GAIN:  angular_gain  <= cfg_data;
        CFG_STOP_DISTANCE: stop_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  ppc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .leader_x         (leader_x),
    .leader_y         (leader_y),
    .follower_x       (follower_x),
    .follower_y       (follower_y),
    .follower_heading (follower_heading),
    .dn_advance       (cell_adv[0]),
    .out_valid        (cell_valid[0]),
    .out_data         (cell_data[0])
  );

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    ppc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .step       (STEP_W'(k)),
      .in_valid   (cell_valid[k]),
      .in_data    (cell_data[k]),
      .up_advance (cell_adv[k]),
      .dn_advance (cell_adv[k+1]),
      .out_valid  (cell_valid[k+1]),
      .out_data   (cell_data[k+1])
    );
  end

  ppc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (cell_valid[CELLS]),
    .in_data       (cell_data[CELLS]),
    .up_advance    (cell_adv[CELLS]),
    .linear_gain   (linear_gain),
    .angular_gain  (angular_gain),
    .stop_distance (stop_distance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .forward_speed (forward_speed),
    .turn_rate     (turn_rate),
    .stopped       (stopped)
  );

endmodule
`default_nettype wire

@@ rtl/ppc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pursuit controller port checker
// Watches the result channel of the controller core.
// ----------------------------------------------------------------------------
module ppc_checker
  import ppc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [16:0]        forward_speed,
  input logic signed [15:0] turn_rate,
  input logic               stopped
);

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(forward_speed) && $stable(turn_rate)
                               && $stable(stopped))
    else $error("stalled result changed");

  a_stop_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && stopped |-> forward_speed == 17'd0)
    else $error("nonzero forward speed while stopped");

  a_speed_max : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> forward_speed <= DIST_MAX)
    else $error("forward speed above its range");

  a_reset_idle : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pursuit_proportional_controller_core ppc_checker u_ppc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .forward_speed (forward_speed),
  .turn_rate     (turn_rate),
  .stopped       (stopped)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Pursuit controller testbench
// Drives leader and follower poses into the controller core under several
// gain and stop-distance settings and with random sender gaps and receiver
// stalls. A scoreboard predicts each steering command and compares it field
// by field with the command that the core returns.
// ----------------------------------------------------------------------------
module tb_top;
  import ppc_pkg::*;

  typedef struct {
    logic [15:0]        leader_x;
    logic [15:0]        leader_y;
    logic [15:0]        follower_x;
    logic [15:0]        follower_y;
    logic signed [15:0] heading;
  } pose_t;

  typedef struct {
    logic [16:0]        speed;
    logic signed [15:0] turn;
    logic               halted;
  } steer_t;

  localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int         ARCTAN_COUNT    = 24;
  localparam int         ROTATIONS       =
    (VECTORING_STEPS < ARCTAN_COUNT) ? VECTORING_STEPS : ARCTAN_COUNT;
  localparam longint     RECIP_GAIN      = 39797;
  localparam longint     RANGE_LIMIT     = 92681;
  localparam int         ITEMS_PER_PHASE = 172;

  // Arctangent of 2^-i as a 32-bit binary angle.
  localparam logic [31:0] ARCTAN_TURNS [0:ARCTAN_COUNT-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  class steering_scoreboard;
    logic [15:0] linear_gain   = 16'd6554;
    logic [15:0] angular_gain  = 16'd32768;
    logic [15:0] stop_distance = 16'd3277;
    steer_t      expected_commands[$];
    int          failures = 0;

    function void write_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_LINEAR_GAIN:   linear_gain = data;
        CFG_ANGULAR_GAIN:  angular_gain = data;
        CFG_STOP_DISTANCE: stop_distance = data;
        default: ;
      endcase
    endfunction

    function steer_t predict_steering(pose_t p);
      longint      dx, dy, x, y, xs, ys, range, err, turn, speed;
      logic [31:0] z;
      logic [15:0] bearing, e16;
      steer_t      r;
      dx = longint'(p.leader_x) - longint'(p.follower_x);
      dy = longint'(p.leader_y) - longint'(p.follower_y);
      z = 32'd0;
      if (dx == 0 && dy == 0) begin
        range = 0;
        bearing = 16'd0;
      end else begin
        x = dx * 256;
        y = dy * 256;
        // Fold the left half plane over so the rotations converge.
        if (x < 0) begin
          x = -x;
          y = -y;
          z = 32'h80000000;
        end
        for (int i = 0; i < ROTATIONS; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_TURNS[i];
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_TURNS[i];
          end
        end
        range = (x * RECIP_GAIN + (longint'(1) << 23)) >>> 24;
        if (range < 0) range = 0;
        if (range > RANGE_LIMIT) range = RANGE_LIMIT;
        bearing = 16'((z + 32'h00008000) >> 16);
      end
      e16 = bearing - p.heading;
      err = longint'($signed(e16));
      turn = (err * longint'(angular_gain) + 32768) >>> 16;
      r.halted = (range < longint'(stop_distance));
      speed = r.halted ? 0 : ((range * longint'(linear_gain) + 32768) >>> 16);
      r.speed = 17'(speed);
      r.turn = 16'(turn);
      return r;
    endfunction

    function void note_request(pose_t p);
      expected_commands.push_back(predict_steering(p));
    endfunction

    function void check_result(steer_t got);
      steer_t want;
      if (expected_commands.size() == 0) begin
        $display("%0t: unexpected result speed %0d turn %0d stopped %0d",
                 $time, got.speed, got.turn, got.halted);
        failures++;
        return;
      end
      want = expected_commands.pop_front();
      if (got.speed !== want.speed) begin
        $display("%0t: forward_speed expected %0d actual %0d",
                 $time, want.speed, got.speed);
        failures++;
      end
      if (got.turn !== want.turn) begin
        $display("%0t: turn_rate expected %0d actual %0d",
                 $time, want.turn, got.turn);
        failures++;
      end
      if (got.halted !== want.halted) begin
        $display("%0t: stopped expected %0d actual %0d",
                 $time, want.halted, got.halted);
        failures++;
      end
    endfunction

    function int pending();
      return expected_commands.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = 2'd0;
  logic [15:0]        cfg_data = 16'd0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        leader_x = 16'd0;
  logic [15:0]        leader_y = 16'd0;
  logic [15:0]        follower_x = 16'd0;
  logic [15:0]        follower_y = 16'd0;
  logic signed [15:0] follower_heading = 16'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [16:0]        forward_speed;
  logic signed [15:0] turn_rate;
  logic               stopped;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  steering_scoreboard sb = new();

  pursuit_proportional_controller_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .leader_x         (leader_x),
    .leader_y         (leader_y),
    .follower_x       (follower_x),
    .follower_y       (follower_y),
    .follower_heading (follower_heading),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .forward_speed    (forward_speed),
    .turn_rate        (turn_rate),
    .stopped          (stopped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    steer_t got;
    if (!rst && out_valid && !out_stall) begin
      got.speed = forward_speed;
      got.turn = turn_rate;
      got.halted = stopped;
      sb.check_result(got);
    end
  end

  function automatic pose_t make_pose(int lx, int ly, int fx, int fy, int h);
    pose_t p;
    p.leader_x = 16'(lx);
    p.leader_y = 16'(ly);
    p.follower_x = 16'(fx);
    p.follower_y = 16'(fy);
    p.heading = 16'(h);
    return p;
  endfunction

  function automatic logic [15:0] nearby(logic [15:0] v);
    int t;
    t = int'(v) + int'($urandom_range(8192)) - 4096;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return 16'(t);
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    int    kind;
    p.leader_x = 16'($urandom);
    p.leader_y = 16'($urandom);
    p.follower_x = 16'($urandom);
    p.follower_y = 16'($urandom);
    p.heading = 16'($urandom);
    kind = $urandom_range(9);
    // Close poses keep the distance near the stop threshold.
    if (kind < 3) begin
      p.follower_x = nearby(p.leader_x);
      p.follower_y = nearby(p.leader_y);
    end else if (kind == 3) begin
      p.follower_x = p.leader_x;
    end else if (kind == 4) begin
      p.follower_y = p.leader_y;
    end else if (kind == 5 && $urandom_range(3) == 0) begin
      p.follower_x = p.leader_x;
      p.follower_y = p.leader_y;
    end
    return p;
  endfunction

  task automatic drive_pose(pose_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    leader_x <= p.leader_x;
    leader_y <= p.leader_y;
    follower_x <= p.follower_x;
    follower_y <= p.follower_y;
    follower_heading <= p.heading;
    do @(posedge clk); while (in_stall);
    sb.note_request(p);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_gains(int lin, int ang, int stop);
    write_register(CFG_LINEAR_GAIN, 16'(lin));
    write_register(CFG_ANGULAR_GAIN, 16'(ang));
    write_register(CFG_STOP_DISTANCE, 16'(stop));
  endtask

  task automatic run_random(int count, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) drive_pose(random_pose());
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed poses with the reset gains.
    drive_pose(make_pose(0, 0, 0, 0, 0));
    drive_pose(make_pose(1000, 2000, 1000, 2000, -32768));
    drive_pose(make_pose(65535, 65535, 65535, 65535, 32767));
    drive_pose(make_pose(30000, 30000, 30000, 30000, 1));
    drive_pose(make_pose(65535, 65535, 0, 0, 0));
    drive_pose(make_pose(0, 0, 65535, 65535, 0));
    drive_pose(make_pose(65535, 0, 0, 65535, 16384));
    drive_pose(make_pose(0, 65535, 65535, 0, -16384));
    drive_pose(make_pose(40000, 20000, 20000, 20000, 0));
    drive_pose(make_pose(20000, 20000, 40000, 20000, 0));
    drive_pose(make_pose(20000, 40000, 20000, 20000, 32767));
    drive_pose(make_pose(20000, 20000, 20000, 40000, -32768));
    drive_pose(make_pose(20001, 20000, 20000, 20000, 0));
    drive_pose(make_pose(20000, 20000, 20001, 20000, 0));
    drive_pose(make_pose(20000, 20001, 20000, 20000, 0));
    drive_pose(make_pose(3277, 0, 0, 0, 0));
    drive_pose(make_pose(3276, 0, 0, 0, 0));
    drive_pose(make_pose(3278, 0, 0, 0, 0));
    drive_pose(make_pose(0, 10000, 0, 0, -16384));
    drive_pose(make_pose(0, 0, 10000, 1, 32767));
    drive_pose(make_pose(0, 1, 10000, 0, -32768));
    drain();
    run_random(ITEMS_PER_PHASE, 0, 0);

    set_gains(65535, 65535, 0);
    drive_pose(make_pose(65535, 65535, 0, 0, 0));
    drive_pose(make_pose(0, 32768, 65535, 32767, -32768));
    run_random(ITEMS_PER_PHASE, 83, 0);

    // The spare register index has no register behind it.
    set_gains(0, 0, 65535);
    write_register(CFG_SPARE_INDEX, 16'($urandom));
    drive_pose(make_pose(65535, 65535, 0, 0, 0));
    run_random(ITEMS_PER_PHASE, 0, 83);

    set_gains($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    run_random(ITEMS_PER_PHASE, 12, 12);

    // Hold the receiver off long enough for the pipeline to back up.
    set_gains(65535, 1, 1);
    hold_left = 300;
    run_random(ITEMS_PER_PHASE, 0, 0);

    set_gains($urandom_range(65535), $urandom_range(65535), $urandom_range(8192));
    run_random(ITEMS_PER_PHASE, 0, 0);

    repeat (30) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
